### hw/rtl/afag_pkg.sv
// Package for the audio frame admission guard: field widths, register indexes,
// action codes, the payload structs and the controller/datapath command and status structs.
// Depends on nothing; every other file of the block imports it.
package afag_pkg;

    localparam int MAX_FRAME_BYTES = 4096;

    localparam int LEN_W      = 13;
    localparam int NUM_W      = 32;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int DUR_W      = 19;
    localparam int TIME_W     = 48;
    localparam int MS_W       = 40;
    localparam int SUM_W      = TIME_W + 3;
    localparam int RATE_W     = 16;
    localparam int US_W       = 24;
    localparam int LOST_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [19:0]        US_PER_S = 20'd1000000;
    localparam logic [DUR_W-1:0]   DUR_MAX  = '1;
    localparam logic [LOST_W-1:0]  LOST_SAT = '1;

    localparam logic [RATE_W-1:0] RST_SAMPLE_RATE   = 16'd8000;
    localparam logic [US_W-1:0]   RST_MAX_BACKLOG   = 24'd400000;
    localparam logic [US_W-1:0]   RST_RESYNC        = 24'd2000000;
    localparam logic [LOST_W-1:0] RST_MAX_LOST      = 8'd50;
    localparam logic [15:0]       RST_IDLE_LIMIT    = 16'd10000;
    localparam logic [15:0]       RST_PING_INTERVAL = 16'd3000;

    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_POLL  = 2'd1;
    localparam logic [1:0] REQ_FEED  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE   = 3'd0,
        CFG_MAX_BACKLOG   = 3'd1,
        CFG_RESYNC        = 3'd2,
        CFG_MAX_LOST      = 3'd3,
        CFG_IDLE_LIMIT    = 3'd4,
        CFG_PING_INTERVAL = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_ACCEPT       = 3'd1,
        ACT_DROP         = 3'd2,
        ACT_PING         = 3'd3,
        ACT_CLOSE_IDLE   = 3'd4,
        ACT_CLOSE_NONBIN = 3'd5,
        ACT_CLOSE_BUSY   = 3'd6,
        ACT_CLOSED       = 3'd7
    } action_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TIME_W-1:0] now_us;
        logic [MS_W-1:0]   now_ms;
        logic [15:0]       idle_ms;
        logic [LEN_W-1:0]  frame_len;
        logic              is_binary;
        logic              fed_ok;
    } in_t;

    typedef struct packed {
        action_t          action;
        logic [DUR_W-1:0] frame_duration_us;
    } out_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL,
        OP_DIV,
        OP_ANCHOR,
        OP_BASE,
        OP_LAG,
        OP_RESYNC,
        OP_LEAD,
        OP_ACCEPT,
        OP_PING,
        OP_FEED_OK,
        OP_REFUSE,
        OP_CLOSE
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    load_in;
        logic    out_load;
        action_t action;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       closed;
        logic       is_binary;
        logic       len_ok;
        logic       fed_ok;
        logic       idle_gt;
        logic       ping_gt;
        logic       busy_close;
        logic       div_last;
        logic       lag_gt;
        logic       lead_gt;
        logic       out_free;
    } dp_stat_t;

endpackage

### hw/rtl/afag_dp.sv
// Datapath of the audio frame admission guard: configuration registers, session state,
// the duration multiplier and bit-serial divider, the schedule arithmetic and the result register.
// Depends on afag_pkg.
module afag_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [afag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [afag_pkg::CFG_DATA_W-1:0] cfg_data,
    input  afag_pkg::in_t                  s_data,
    input  afag_pkg::dp_cmd_t              cmd,
    output afag_pkg::dp_stat_t             stat,
    output logic                           m_valid,
    input  logic                           m_ready,
    output afag_pkg::out_t                 m_data
);
    import afag_pkg::*;

    // Configuration.
    logic [RATE_W-1:0] sample_rate_reg;
    logic [US_W-1:0]   max_backlog_reg;
    logic [US_W-1:0]   resync_reg;
    logic [LOST_W-1:0] max_lost_reg;
    logic [15:0]       idle_limit_reg;
    logic [15:0]       ping_interval_reg;

    // Session state.
    logic              anchored_reg, anchored_next;
    logic [TIME_W-1:0] anchor_reg, anchor_next;
    logic [TIME_W-1:0] accepted_reg, accepted_next;
    logic [MS_W-1:0]   ping_stamp_reg, ping_stamp_next;
    logic [LOST_W-1:0] refusal_reg, refusal_next;
    logic              closed_reg, closed_next;

    // Working registers.
    in_t               in_reg;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [TIME_W:0]   base_reg, base_next;
    logic [SUM_W-1:0]  lag_reg, lag_next;
    logic [SUM_W-1:0]  lead_reg, lead_next;
    logic              m_valid_reg;
    out_t              m_data_reg;

    logic [RATE_W:0]   shl;
    logic [RATE_W+1:0] trial;
    logic [MS_W:0]     ping_diff;
    logic [LOST_W-1:0] refusal_inc;

    always_comb begin
        shl         = {rem_reg, num_reg[NUM_W-1]};
        trial       = {1'b0, shl} - {2'b00, sample_rate_reg};
        ping_diff   = {1'b0, in_reg.now_ms} - {1'b0, ping_stamp_reg};
        refusal_inc = (refusal_reg == LOST_SAT) ? LOST_SAT : refusal_reg + 1'b1;
    end

    always_comb begin
        stat.req_type   = in_reg.req_type;
        stat.closed     = closed_reg;
        stat.is_binary  = in_reg.is_binary;
        stat.len_ok     = (in_reg.frame_len != '0) &&
                          (in_reg.frame_len <= LEN_W'(MAX_FRAME_BYTES));
        stat.fed_ok     = in_reg.fed_ok;
        stat.idle_gt    = in_reg.idle_ms > idle_limit_reg;
        stat.ping_gt    = !ping_diff[MS_W] &&
                          (ping_diff[MS_W-1:0] > {(MS_W-16)'(0), ping_interval_reg});
        stat.busy_close = refusal_inc >= max_lost_reg;
        stat.div_last   = cnt_reg == '1;
        stat.lag_gt     = !lag_reg[SUM_W-1] &&
                          (lag_reg[SUM_W-2:0] > {(SUM_W-1-US_W)'(0), resync_reg});
        stat.lead_gt    = !lead_reg[SUM_W-1] &&
                          (lead_reg[SUM_W-2:0] > {(SUM_W-1-US_W)'(0), max_backlog_reg});
        stat.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        anchored_next   = anchored_reg;
        anchor_next     = anchor_reg;
        accepted_next   = accepted_reg;
        ping_stamp_next = ping_stamp_reg;
        refusal_next    = refusal_reg;
        closed_next     = closed_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        dur_next        = dur_reg;
        base_next       = base_reg;
        lag_next        = lag_reg;
        lead_next       = lead_reg;
        unique case (cmd.op)
            OP_NOP: begin
            end
            OP_MUL: begin
                num_next = {(NUM_W-LEN_W)'(0), in_reg.frame_len} * NUM_W'(US_PER_S);
                rem_next = '0;
                cnt_next = '0;
            end
            OP_DIV: begin
                // One restoring step: the quotient bit shifts in where the numerator left.
                if (!trial[RATE_W+1]) begin
                    rem_next = trial[RATE_W-1:0];
                end else begin
                    rem_next = shl[RATE_W-1:0];
                end
                num_next = {num_reg[NUM_W-2:0], !trial[RATE_W+1]};
                cnt_next = cnt_reg + 1'b1;
            end
            OP_ANCHOR: begin
                dur_next = (num_reg > {(NUM_W-DUR_W)'(0), DUR_MAX}) ?
                           DUR_MAX : num_reg[DUR_W-1:0];
                if (!anchored_reg) begin
                    anchored_next = 1'b1;
                    anchor_next   = in_reg.now_us;
                    accepted_next = '0;
                end
            end
            OP_BASE: begin
                base_next = {1'b0, anchor_reg} + {1'b0, accepted_reg};
            end
            OP_LAG: begin
                lag_next = {3'b000, in_reg.now_us} - {2'b00, base_reg};
            end
            OP_RESYNC: begin
                if (stat.lag_gt) begin
                    anchor_next   = in_reg.now_us;
                    accepted_next = '0;
                    base_next     = {1'b0, in_reg.now_us};
                end
            end
            OP_LEAD: begin
                lead_next = {2'b00, base_reg} + {(SUM_W-DUR_W)'(0), dur_reg}
                          - {3'b000, in_reg.now_us};
            end
            OP_ACCEPT: begin
                accepted_next = accepted_reg + {(TIME_W-DUR_W)'(0), dur_reg};
            end
            OP_PING: begin
                ping_stamp_next = in_reg.now_ms;
            end
            OP_FEED_OK: begin
                refusal_next = '0;
            end
            OP_REFUSE: begin
                refusal_next = refusal_inc;
                if (stat.busy_close) begin
                    closed_next = 1'b1;
                end
            end
            OP_CLOSE: begin
                closed_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg   <= RST_SAMPLE_RATE;
            max_backlog_reg   <= RST_MAX_BACKLOG;
            resync_reg        <= RST_RESYNC;
            max_lost_reg      <= RST_MAX_LOST;
            idle_limit_reg    <= RST_IDLE_LIMIT;
            ping_interval_reg <= RST_PING_INTERVAL;
            anchored_reg      <= 1'b0;
            anchor_reg        <= '0;
            accepted_reg      <= '0;
            ping_stamp_reg    <= '0;
            refusal_reg       <= '0;
            closed_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_SAMPLE_RATE:   sample_rate_reg   <= cfg_data[RATE_W-1:0];
                    CFG_MAX_BACKLOG:   max_backlog_reg   <= cfg_data[US_W-1:0];
                    CFG_RESYNC:        resync_reg        <= cfg_data[US_W-1:0];
                    CFG_MAX_LOST:      max_lost_reg      <= cfg_data[LOST_W-1:0];
                    CFG_IDLE_LIMIT:    idle_limit_reg    <= cfg_data[15:0];
                    CFG_PING_INTERVAL: ping_interval_reg <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            anchored_reg   <= anchored_next;
            anchor_reg     <= anchor_next;
            accepted_reg   <= accepted_next;
            ping_stamp_reg <= ping_stamp_next;
            refusal_reg    <= refusal_next;
            closed_reg     <= closed_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        dur_reg  <= dur_next;
        base_reg <= base_next;
        lag_reg  <= lag_next;
        lead_reg <= lead_next;
        if (cmd.out_load) begin
            m_data_reg.action <= cmd.action;
            // Only accepted and dropped frames report a duration.
            m_data_reg.frame_duration_us <=
                (cmd.action == ACT_ACCEPT || cmd.action == ACT_DROP) ? dur_reg : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hw/rtl/afag_ctrl.sv
// Controller of the audio frame admission guard: a state machine that sequences the datapath
// through decode, duration division, schedule checks and result delivery.
// Depends on afag_pkg.
module afag_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  afag_pkg::dp_stat_t  stat,
    output afag_pkg::dp_cmd_t   cmd
);
    import afag_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_ANCHOR,
        ST_BASE,
        ST_LAG,
        ST_RESYNC,
        ST_LEAD,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    state_t  state_reg, state_next;
    action_t act_reg, act_next;

    always_comb begin
        state_next  = state_reg;
        act_next    = act_reg;
        s_ready     = 1'b0;
        cmd.op      = OP_NOP;
        cmd.load_in = 1'b0;
        cmd.out_load = 1'b0;
        cmd.action  = act_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_EMIT;
                act_next   = ACT_NONE;
                if (stat.closed) begin
                    act_next = ACT_CLOSED;
                end else begin
                    unique case (stat.req_type)
                        REQ_FRAME: begin
                            if (!stat.is_binary) begin
                                cmd.op   = OP_CLOSE;
                                act_next = ACT_CLOSE_NONBIN;
                            end else if (stat.len_ok) begin
                                state_next = ST_MUL;
                            end
                        end
                        REQ_POLL: begin
                            if (stat.idle_gt) begin
                                cmd.op   = OP_CLOSE;
                                act_next = ACT_CLOSE_IDLE;
                            end else if (stat.ping_gt) begin
                                cmd.op   = OP_PING;
                                act_next = ACT_PING;
                            end
                        end
                        REQ_FEED: begin
                            if (stat.fed_ok) begin
                                cmd.op = OP_FEED_OK;
                            end else begin
                                cmd.op = OP_REFUSE;
                                if (stat.busy_close) begin
                                    act_next = ACT_CLOSE_BUSY;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL: begin
                cmd.op     = OP_MUL;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (stat.div_last) begin
                    state_next = ST_ANCHOR;
                end
            end
            ST_ANCHOR: begin
                cmd.op     = OP_ANCHOR;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                cmd.op     = OP_BASE;
                state_next = ST_LAG;
            end
            ST_LAG: begin
                cmd.op     = OP_LAG;
                state_next = ST_RESYNC;
            end
            ST_RESYNC: begin
                cmd.op     = OP_RESYNC;
                state_next = ST_LEAD;
            end
            ST_LEAD: begin
                cmd.op     = OP_LEAD;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (stat.lead_gt) begin
                    act_next = ACT_DROP;
                end else begin
                    cmd.op   = OP_ACCEPT;
                    act_next = ACT_ACCEPT;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            act_reg   <= ACT_NONE;
        end else begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

endmodule

### hw/rtl/audio_frame_admission_guard.sv
// Audio frame admission guard, top level: joins the controller and the datapath.
// Valid binary frame items pass through the 32-step serial divider for the duration and then
// the schedule checks before their result is loaded. Other items, and all items once the
// session is closed, go from decode straight to the result register, one item at a time.
// A waiting result only holds back the emit of the next item, never its acceptance.
// Reset (aresetn, synchronous, active low) restores default configuration and an open session.
module audio_frame_admission_guard (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  afag_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output afag_pkg::out_t                  m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [afag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afag_pkg::CFG_DATA_W-1:0] cfg_data
);
    import afag_pkg::*;

    // The controller issues one datapath operation per cycle and reads back status
    // flags (compare outcomes, divider progress, result register occupancy).
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration writes go straight into the registers, so the port is always ready.
    // Writes to indexes beyond the register list are taken and ignored.
    assign cfg_ready = 1'b1;

    afag_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the session state, the configuration registers and the
    // result register that drives the m_ channel.
    afag_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### hw/rtl/afag_checker.sv
// Port-level checker for the audio frame admission guard, with the bind that attaches it
// to the top level. Depends on afag_pkg.
module afag_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input afag_pkg::in_t                   s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input afag_pkg::out_t                  m_data
);
    import afag_pkg::*;

    // An offered item stays offered and unchanged until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item changed while waiting");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // One item at a time: the block is busy in the cycle after an acceptance.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an acceptance");

    // Only accepted and dropped frames carry a duration.
    a_dur_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_data.action == ACT_ACCEPT || m_data.action == ACT_DROP)
        |-> m_data.frame_duration_us == '0)
        else $error("duration on a result that is not a frame decision");

    // A frame of at least one sample lasts at least some microseconds.
    a_dur_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action == ACT_ACCEPT || m_data.action == ACT_DROP)
        |-> m_data.frame_duration_us != '0)
        else $error("frame decision with zero duration");

endmodule

bind audio_frame_admission_guard afag_checker u_afag_checker (.*);

### dv/audio_frame_admission_guard_tb.sv
`timescale 1ns / 100ps
// Testbench for audio_frame_admission_guard: a scoreboard class predicts every result
// from the items the block accepts, and plain tasks drive the item and register channels.
// Depends on afag_pkg and the audio_frame_admission_guard RTL only.
module audio_frame_admission_guard_tb;
    import afag_pkg::*;

    // Request code 3 has no meaning in the block; it must answer with no action.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    // Register indexes beyond the map; writes to them must leave the block unchanged.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;
    // Even with the receiver stalling most of the time, some handshake
    // completes far sooner than this limit.
    localparam int STALL_LIMIT = 2000;
    // Quiet time after the last result.
    localparam int SETTLE_CYCLES = 60;

    // The scoreboard keeps its own copy of the register file and session state,
    // predicts the result of each accepted item and checks results in order.
    class guard_scoreboard;
        logic [RATE_W-1:0] rate;
        logic [US_W-1:0]   backlog_lim;
        logic [US_W-1:0]   resync_lim;
        logic [LOST_W-1:0] lost_lim;
        logic [15:0]       idle_lim;
        logic [15:0]       ping_gap;

        bit                anchored;
        logic [TIME_W-1:0] anchor_us;
        logic [TIME_W-1:0] audio_us;
        logic [MS_W-1:0]   ping_stamp;
        logic [LOST_W-1:0] refusals;
        bit                closed;

        out_t outstanding[$];
        int   errors;
        int   items;
        int   reanchors;
        int   act_seen[8];

        function new();
            restore_defaults();
        endfunction

        function void restore_defaults();
            rate        = RST_SAMPLE_RATE;
            backlog_lim = RST_MAX_BACKLOG;
            resync_lim  = RST_RESYNC;
            lost_lim    = RST_MAX_LOST;
            idle_lim    = RST_IDLE_LIMIT;
            ping_gap    = RST_PING_INTERVAL;
            anchored    = 1'b0;
            anchor_us   = '0;
            audio_us    = '0;
            ping_stamp  = '0;
            refusals    = '0;
            closed      = 1'b0;
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SAMPLE_RATE:   rate        = val[RATE_W-1:0];
                CFG_MAX_BACKLOG:   backlog_lim = val[US_W-1:0];
                CFG_RESYNC:        resync_lim  = val[US_W-1:0];
                CFG_MAX_LOST:      lost_lim    = val[LOST_W-1:0];
                CFG_IDLE_LIMIT:    idle_lim    = val[15:0];
                CFG_PING_INTERVAL: ping_gap    = val[15:0];
                default: ;
            endcase
        endfunction

        // Floor of samples * 1e6 / rate, saturated; a zero rate saturates too.
        function logic [DUR_W-1:0] frame_duration(logic [LEN_W-1:0] len);
            longint unsigned len_v, rate_v, scale_v, q;
            if (rate == '0) return DUR_MAX;
            len_v   = len;
            rate_v  = rate;
            scale_v = US_PER_S;
            q = (len_v * scale_v) / rate_v;
            if (q > longint'(DUR_MAX)) return DUR_MAX;
            return q[DUR_W-1:0];
        endfunction

        // True when one more refusal would close the session.
        function bit refusal_closes();
            logic [LOST_W-1:0] next_v;
            next_v = (refusals == LOST_SAT) ? refusals : refusals + 1'b1;
            return next_v >= lost_lim;
        endfunction

        function out_t predict_outcome(in_t it);
            out_t   res;
            longint now_v, base_v, lag_v, lead_v, lim_v, dur_v;
            logic [DUR_W-1:0] dur;
            res.action            = ACT_NONE;
            res.frame_duration_us = '0;
            if (closed) begin
                res.action = ACT_CLOSED;
                return res;
            end
            case (it.req_type)
                REQ_FRAME: begin
                    if (!it.is_binary) begin
                        closed     = 1'b1;
                        res.action = ACT_CLOSE_NONBIN;
                    end else if (it.frame_len != '0 && it.frame_len <= MAX_FRAME_BYTES) begin
                        dur = frame_duration(it.frame_len);
                        res.frame_duration_us = dur;
                        if (!anchored) begin
                            anchored  = 1'b1;
                            anchor_us = it.now_us;
                            audio_us  = '0;
                        end
                        now_v  = it.now_us;
                        base_v = anchor_us;
                        lag_v  = audio_us;
                        base_v = base_v + lag_v;
                        lag_v  = now_v - base_v;
                        lim_v  = resync_lim;
                        if (lag_v > lim_v) begin
                            anchor_us = it.now_us;
                            audio_us  = '0;
                            base_v    = now_v;
                            reanchors++;
                        end
                        dur_v  = dur;
                        lead_v = base_v + dur_v - now_v;
                        lim_v  = backlog_lim;
                        if (lead_v > lim_v) begin
                            res.action = ACT_DROP;
                        end else begin
                            audio_us   = audio_us + dur;
                            res.action = ACT_ACCEPT;
                        end
                    end
                end
                REQ_POLL: begin
                    now_v  = it.now_ms;
                    base_v = ping_stamp;
                    lim_v  = ping_gap;
                    if (it.idle_ms > idle_lim) begin
                        closed     = 1'b1;
                        res.action = ACT_CLOSE_IDLE;
                    end else if (now_v - base_v > lim_v) begin
                        ping_stamp = it.now_ms;
                        res.action = ACT_PING;
                    end
                end
                REQ_FEED: begin
                    if (it.fed_ok) begin
                        refusals = '0;
                    end else begin
                        if (refusals != LOST_SAT) refusals = refusals + 1'b1;
                        if (refusals >= lost_lim) begin
                            closed     = 1'b1;
                            res.action = ACT_CLOSE_BUSY;
                        end
                    end
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_item(in_t it);
            out_t res;
            res = predict_outcome(it);
            outstanding.push_back(res);
            act_seen[res.action]++;
            items++;
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (outstanding.size() == 0) begin
                errors++;
                $error("result with no item outstanding: action %0d duration %0d",
                       got.action, got.frame_duration_us);
                return;
            end
            want = outstanding.pop_front();
            if (got.action !== want.action) begin
                errors++;
                $error("action: expected %0d, actual %0d", want.action, got.action);
            end
            if (got.frame_duration_us !== want.frame_duration_us) begin
                errors++;
                $error("frame_duration_us: expected %0d, actual %0d",
                       want.frame_duration_us, got.frame_duration_us);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    guard_scoreboard sb;

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int settings_used;
    int stall_cycles;
    logic [TIME_W-1:0] wall_us;
    logic [MS_W-1:0]   wall_ms;
    string closer_desc;

    audio_frame_admission_guard dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // The receiver stalls at random with the current idle percentage.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every result taken by the receiver is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // The watchdog ends a run in which no channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
            $display("audio_frame_admission_guard_tb: errors");
            $finish;
        end
    end

    // Every field gets random content, so that fields the request ignores still toggle.
    function automatic in_t noise_item(logic [1:0] req);
        in_t         it;
        logic [63:0] r;
        r            = {$urandom(), $urandom()};
        it.now_us    = r[TIME_W-1:0];
        r            = {$urandom(), $urandom()};
        it.now_ms    = r[MS_W-1:0];
        it.idle_ms   = 16'($urandom());
        it.frame_len = LEN_W'($urandom());
        it.is_binary = 1'($urandom());
        it.fed_ok    = 1'($urandom());
        it.req_type  = req;
        return it;
    endfunction

    // Offers one item and returns at the edge where it is accepted. Valid is only
    // lowered for a gap, so back-to-back items keep it high without a glitch.
    task automatic send_item(input in_t it);
        if (items_sent < 480) begin
            send_idle_pct = 31;
            recv_idle_pct = 63;
        end else if (items_sent < 960) begin
            send_idle_pct = 63;
            recv_idle_pct = 31;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_frame(input logic [TIME_W-1:0] now, input logic [LEN_W-1:0] len);
        in_t it;
        it           = noise_item(REQ_FRAME);
        it.now_us    = now;
        it.frame_len = len;
        it.is_binary = 1'b1;
        send_item(it);
    endtask

    task automatic send_poll(input logic [MS_W-1:0] now, input logic [15:0] idle);
        in_t it;
        it         = noise_item(REQ_POLL);
        it.now_ms  = now;
        it.idle_ms = idle;
        send_item(it);
    endtask

    task automatic send_feed(input logic ok);
        in_t it;
        it        = noise_item(REQ_FEED);
        it.fed_ok = ok;
        send_item(it);
    endtask

    // Drops valid and waits until every predicted result has been taken; the block
    // answers every item, so it is idle from then on.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.apply_register(idx, val);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] rate_v, backlog_v, resync_v,
                                input logic [CFG_DATA_W-1:0] lost_v, idle_v, ping_v,
                                input bit with_unmapped);
        drain();
        if (with_unmapped) begin
            write_reg(CFG_UNMAPPED_A, 24'($urandom()));
            write_reg(CFG_UNMAPPED_B, 24'($urandom()));
        end
        write_reg(CFG_SAMPLE_RATE, rate_v);
        write_reg(CFG_MAX_BACKLOG, backlog_v);
        write_reg(CFG_RESYNC, resync_v);
        write_reg(CFG_MAX_LOST, lost_v);
        write_reg(CFG_IDLE_LIMIT, idle_v);
        write_reg(CFG_PING_INTERVAL, ping_v);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random traffic that keeps the session open. Frames mostly follow a wall clock
    // that advances by about one frame time, so the schedule drifts between accept
    // and drop; jumps force re-anchoring and stray timestamps act as noise. Polls
    // follow a millisecond clock near the ping spacing, and refusals stop one short
    // of the close limit.
    task automatic stream_items(input int count);
        in_t              it;
        int               pick;
        int               sel;
        logic [DUR_W-1:0] dur;
        logic [63:0]      r;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                it           = noise_item(REQ_FRAME);
                it.is_binary = 1'b1;
                sel = $urandom_range(99);
                if (sel < 3)       it.frame_len = '0;
                else if (sel < 8)  it.frame_len = LEN_W'($urandom_range(MAX_FRAME_BYTES + 1,
                                                                        8191));
                else if (sel < 18) it.frame_len = LEN_W'($urandom_range(1, 16));
                else               it.frame_len = LEN_W'($urandom_range(1, MAX_FRAME_BYTES));
                dur = sb.frame_duration(it.frame_len);
                sel = $urandom_range(99);
                if (sel < 3) begin
                    // A stray timestamp; the clock only follows it forward.
                    if (it.now_us > wall_us) wall_us = it.now_us;
                end else begin
                    if (sel < 9) wall_us = wall_us + $urandom_range(1000000, 40000000);
                    else         wall_us = wall_us + $urandom_range(0, 2 * dur + 2);
                    it.now_us = wall_us;
                end
                send_item(it);
            end else if (pick < 75) begin
                it = noise_item(REQ_POLL);
                if ($urandom_range(99) < 5) begin
                    if (it.now_ms > wall_ms) wall_ms = it.now_ms;
                end else begin
                    wall_ms   = wall_ms + $urandom_range(0, 2 * sb.ping_gap + 2);
                    it.now_ms = wall_ms;
                end
                it.idle_ms = 16'($urandom_range(0, sb.idle_lim));
                send_item(it);
            end else if (pick < 95) begin
                it        = noise_item(REQ_FEED);
                it.fed_ok = ($urandom_range(99) >= 60) || sb.refusal_closes();
                send_item(it);
            end else begin
                send_item(noise_item(REQ_UNKNOWN));
            end
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] lost_v;
        int closer;

        sb            = new();
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_data        <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_SAMPLE_RATE;
        cfg_data      <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        settings_used = 1;
        wall_us       = 48'd5000000;
        wall_ms       = 40'd100000;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        sb.restore_defaults();

        // Directed part at the reset settings: rate 8000, backlog 400 ms,
        // resync 2 s, close after 50 refusals, idle 10 s, ping every 3 s.
        send_poll(40'd0, 16'd0);                // no ping yet
        send_poll(40'd3001, RST_IDLE_LIMIT);    // ping, idle exactly at the limit
        send_poll(40'd6001, 16'd0);             // spacing equal to the interval
        send_poll(40'hFF_FFFF_FFFF, 16'd0);     // clock at its top, ping
        send_poll(40'd5, 16'd0);                // clock went backward
        send_feed(1'b0);
        send_feed(1'b0);
        send_feed(1'b1);                        // clears the refusal count
        send_item(noise_item(REQ_UNKNOWN));
        send_frame(48'd1000, 13'd0);            // empty binary frame
        send_frame(48'd1000, 13'd4097);         // just over the size limit
        send_frame(48'd1000, 13'h1FFF);         // largest encodable length
        send_frame(48'd1000, 13'd1);            // anchors, accepts 125 us
        send_frame(48'd1000, 13'd4096);         // 512 ms would overrun the backlog
        send_frame(48'd1125, 13'd3200);         // lead lands exactly on the backlog
        send_frame(48'd1125, 13'd1);            // one sample too many
        send_frame(48'd2401126, 13'd8);         // lag one past resync, re-anchors
        send_frame(48'hFFFF_FFFF_FFFF, 13'd3200);
        send_frame(48'd0, 13'd8);               // clock behind the schedule
        send_frame(48'd0, 13'd4096);
        send_frame(48'd3000000, 13'd80);

        // Register settings, from the usual case to the extremes and random values.
        program_regs(24'd8000, 24'd400000, 24'd2000000, 24'd255, 24'd65535, 24'd3000, 1'b0);
        stream_items(300);
        program_regs(24'd48000, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 1'b0);
        stream_items(200);
        program_regs(24'd44100, 24'hFFFFFF, 24'hFFFFFF, 24'd50, 24'd10000, 24'd65535, 1'b0);
        stream_items(300);
        program_regs(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                     24'($urandom()), 24'($urandom()), 1'b1);
        stream_items(300);
        program_regs(24'd0, 24'd600000, 24'd1000000, 24'd20, 24'd30000, 24'd1000, 1'b0);
        stream_items(150);
        program_regs(24'd1000, 24'd800000, 24'd3000000, 24'd8, 24'd500, 24'd250, 1'b0);
        stream_items(150);

        // Closing the session is final, so one way of closing is picked at random
        // for the end of the run, then random items must all see the closed answer.
        closer = $urandom_range(2);
        lost_v = 24'd200;
        if (closer == 2) lost_v = $urandom_range(1) ? 24'd0 : 24'($urandom_range(1, 4));
        program_regs(24'd16000, 24'd400000, 24'd2000000, lost_v,
                     24'($urandom_range(0, 65534)), 24'd3000, 1'b0);
        case (closer)
            0: begin
                closer_desc = "a non-binary frame";
                begin
                    in_t it;
                    it           = noise_item(REQ_FRAME);
                    it.is_binary = 1'b0;
                    send_item(it);
                end
            end
            1: begin
                closer_desc = "an idle timeout";
                send_poll(wall_ms, sb.idle_lim + 16'd1);
            end
            default: begin
                closer_desc = "speaker refusals";
                while (!sb.closed) send_feed(1'b0);
            end
        endcase
        for (int k = 0; k < 24; k++) send_item(noise_item(2'($urandom())));

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d items over %0d register settings: %0d accepted, %0d dropped,",
                 sb.items, settings_used, sb.act_seen[ACT_ACCEPT], sb.act_seen[ACT_DROP]);
        $display("%0d pings and %0d re-anchors; closed by %s, then %0d closed answers.",
                 sb.act_seen[ACT_PING], sb.reanchors, closer_desc, sb.act_seen[ACT_CLOSED]);
        if (sb.errors == 0 && sb.outstanding.size() == 0) begin
            $display("audio_frame_admission_guard_tb: clean");
        end else begin
            $display("audio_frame_admission_guard_tb: errors");
        end
        $finish;
    end

endmodule
